@@ hdl/prt_pkg.sv @@
// ----------------------------------------------------------------------------
// prt_pkg: shared constants and types of the pending request tracker
// Table geometry, operation codes, sequencer states and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package prt_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int STAMP_W     = 32;
  localparam int TOKEN_W     = 64;
  localparam int MODE_W      = 3;
  localparam int AGE_W       = 16;
  localparam int ADDR_W      = 3;
  localparam int DATA_W      = 32;

  localparam logic [AGE_W-1:0] MAX_AGE_RST = 16'd5;

  // Register index decoded from paddr[2]
  localparam logic REG_MAX_AGE = 1'b0;

  typedef enum logic [MODE_W-1:0] {
    MODE_RECORD = 3'd0,
    MODE_CHECK  = 3'd1,
    MODE_TICK   = 3'd2,
    MODE_REAP   = 3'd3,
    MODE_CLEAR  = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

endpackage : prt_pkg

`default_nettype wire

@@ hdl/pending_request_tracker_top.sv @@
// ----------------------------------------------------------------------------
// pending_request_tracker_top: outstanding request table with timeout
// Records request tokens with a time stamp, matches and removes them, and
// reaps entries older than max_age with an in-place compacting scan.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake             Payload
//  in_       input      in_valid / in_stall   in_mode, in_token
//  out_      output     out_valid / out_stall out_found, out_table_full,
//                                             out_reaped_count, out_occupancy
//  config    input      APB psel/penable      max_age at byte address 0
//
//  Sequence: record, tick, clear and unused modes go from idle straight to the
//  final step, which loads the output register; check and reap first run a
//  one-entry-per-cycle scan through the shared compare unit.
//  Reset (rst_n low, synchronous) empties the table, zeroes time, sets
//  max_age to 5. The table contents themselves are not cleared.
//  in_stall is high from acceptance until the result is loaded into the
//  output register; a held output stalls only the final sequencer step.
// ----------------------------------------------------------------------------
`default_nettype none

module pending_request_tracker_top
  import prt_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  // request input
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [MODE_W-1:0]  in_mode,
  input  wire logic [TOKEN_W-1:0] in_token,
  // result output
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_found,
  output logic                    out_table_full,
  output logic [CNT_W-1:0]        out_reaped_count,
  output logic [CNT_W-1:0]        out_occupancy,
  // configuration
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [ADDR_W-1:0]  paddr,
  input  wire logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]       prdata,
  output logic                    pready
);

  // table storage, written one entry per cycle, no reset
  logic [TOKEN_W-1:0] tok_mem   [TABLE_DEPTH];
  logic [STAMP_W-1:0] stamp_mem [TABLE_DEPTH];

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [STAMP_W-1:0] now_r, now_nxt;
  logic [AGE_W-1:0]   max_age_r, max_age_nxt;
  logic               reap_op_r, reap_op_nxt;
  logic [TOKEN_W-1:0] key_r, key_nxt;
  logic [CNT_W-1:0]   rd_r, rd_nxt;
  logic [CNT_W-1:0]   wr_r, wr_nxt;
  logic               found_r, found_nxt;
  logic               full_r, full_nxt;
  logic [CNT_W-1:0]   reaped_r, reaped_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic               out_found_r, out_found_nxt;
  logic               out_full_r, out_full_nxt;
  logic [CNT_W-1:0]   out_reaped_r, out_reaped_nxt;
  logic [CNT_W-1:0]   out_occ_r, out_occ_nxt;

  logic               in_acc;
  logic               out_acc;
  logic               cfg_wr;
  logic               drop;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic [TOKEN_W-1:0] mem_wtok;
  logic [STAMP_W-1:0] mem_wstamp;
  logic [TOKEN_W-1:0] rd_tok_r;
  logic [STAMP_W-1:0] rd_stamp_r;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid_r && !out_stall;
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign prdata   = (paddr[2] == REG_MAX_AGE) ? DATA_W'(max_age_r) : '0;

  assign out_valid        = out_valid_r;
  assign out_found        = out_found_r;
  assign out_table_full   = out_full_r;
  assign out_reaped_count = out_reaped_r;
  assign out_occupancy    = out_occ_r;

  prt_scan_unit u_scan (
    .reap_mode     (reap_op_r),
    .already_found (found_r),
    .key_token     (key_r),
    .entry_token   (rd_tok_r),
    .entry_stamp   (rd_stamp_r),
    .now           (now_r),
    .max_age       (max_age_r),
    .drop          (drop)
  );

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    now_nxt        = now_r;
    max_age_nxt    = max_age_r;
    reap_op_nxt    = reap_op_r;
    key_nxt        = key_r;
    rd_nxt         = rd_r;
    wr_nxt         = wr_r;
    found_nxt      = found_r;
    full_nxt       = full_r;
    reaped_nxt     = reaped_r;
    out_valid_nxt  = out_valid_r;
    out_found_nxt  = out_found_r;
    out_full_nxt   = out_full_r;
    out_reaped_nxt = out_reaped_r;
    out_occ_nxt    = out_occ_r;
    mem_we         = 1'b0;
    mem_waddr      = count_r[IDX_W-1:0];
    mem_wtok       = in_token;
    mem_wstamp     = now_r;

    if (cfg_wr && (paddr[2] == REG_MAX_AGE)) begin
      max_age_nxt = pwdata[AGE_W-1:0];
    end

    // drop the held result once it is taken
    if (out_acc) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          found_nxt   = 1'b0;
          full_nxt    = 1'b0;
          reaped_nxt  = '0;
          rd_nxt      = '0;
          wr_nxt      = '0;
          key_nxt     = in_token;
          reap_op_nxt = (in_mode == MODE_REAP);
          state_nxt   = ST_FIN;
          case (in_mode)
            MODE_RECORD: begin
              if (count_r >= CNT_W'(TABLE_DEPTH)) begin
                full_nxt = 1'b1;
              end else begin
                mem_we    = 1'b1;
                count_nxt = count_r + 1'b1;
              end
            end
            MODE_CHECK, MODE_REAP: begin
              state_nxt = ST_SCAN;
            end
            MODE_TICK: begin
              now_nxt = now_r + 1'b1;
            end
            MODE_CLEAR: begin
              reaped_nxt = count_r;
              count_nxt  = '0;
            end
            default: begin
            end
          endcase
        end
      end

      ST_SCAN: begin
        if (rd_r == count_r) begin
          // scan done: survivors sit below the write pointer
          if (reap_op_r) begin
            reaped_nxt = count_r - wr_r;
          end
          count_nxt = wr_r;
          state_nxt = ST_FIN;
        end else begin
          rd_nxt = rd_r + 1'b1;
          if (drop) begin
            found_nxt = found_r || !reap_op_r;
          end else begin
            // compact: move the kept entry down to the write pointer
            mem_we     = 1'b1;
            mem_waddr  = wr_r[IDX_W-1:0];
            mem_wtok   = rd_tok_r;
            mem_wstamp = rd_stamp_r;
            wr_nxt     = wr_r + 1'b1;
          end
        end
      end

      ST_FIN: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_found_nxt  = found_r;
          out_full_nxt   = full_r;
          out_reaped_nxt = reaped_r;
          out_occ_nxt    = count_r;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Read at the next read pointer so the registered entry lines up with rd_r.
  // Compaction writes land below the read pointer, so no write hits the
  // entry being read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      tok_mem[mem_waddr]   <= mem_wtok;
      stamp_mem[mem_waddr] <= mem_wstamp;
    end
    rd_tok_r   <= tok_mem[rd_nxt[IDX_W-1:0]];
    rd_stamp_r <= stamp_mem[rd_nxt[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      now_r       <= '0;
      max_age_r   <= MAX_AGE_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      now_r       <= now_nxt;
      max_age_r   <= max_age_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    reap_op_r    <= reap_op_nxt;
    key_r        <= key_nxt;
    rd_r         <= rd_nxt;
    wr_r         <= wr_nxt;
    found_r      <= found_nxt;
    full_r       <= full_nxt;
    reaped_r     <= reaped_nxt;
    out_found_r  <= out_found_nxt;
    out_full_r   <= out_full_nxt;
    out_reaped_r <= out_reaped_nxt;
    out_occ_r    <= out_occ_nxt;
  end

endmodule : pending_request_tracker_top

`default_nettype wire

@@ hdl/prt_scan_unit.sv @@
// ----------------------------------------------------------------------------
// prt_scan_unit: per-entry keep/drop decision
// Shared compare unit used once per cycle while the table is scanned.
// ----------------------------------------------------------------------------
`default_nettype none

module prt_scan_unit
  import prt_pkg::*;
(
  input  wire logic               reap_mode,
  input  wire logic               already_found,
  input  wire logic [TOKEN_W-1:0] key_token,
  input  wire logic [TOKEN_W-1:0] entry_token,
  input  wire logic [STAMP_W-1:0] entry_stamp,
  input  wire logic [STAMP_W-1:0] now,
  input  wire logic [AGE_W-1:0]   max_age,
  output logic                    drop
);

  logic [STAMP_W-1:0] age;
  logic               expired;
  logic               match;

  // modular age, wraps with the time counter
  assign age     = now - entry_stamp;
  assign expired = age > STAMP_W'(max_age);
  assign match   = (entry_token == key_token);

  // drop only the first matching entry on a check
  assign drop = reap_mode ? expired : (match && !already_found);

endmodule : prt_scan_unit

`default_nettype wire
